[rtl/ndl_pkg.sv]
// Shared types and constants for the nearest-neighbor downscaler with luma conversion.
// Holds the payload structs, register indexes, color modes and luma weights.
// No dependencies.
`timescale 1ns / 1ps

package ndl_pkg;

    localparam int unsigned PIX_W             = 8;
    localparam int unsigned CFG_W             = 13;
    localparam int unsigned MODE_W            = 2;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned MAX_DIMENSION_DEF = 4096;

    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = CFG_W'(480);
    localparam logic [CFG_W-1:0] TARGET_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] TARGET_HEIGHT_RST = CFG_W'(480);

    // BT.601-style luma weights in 8-bit fixed point.
    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;
    localparam logic [PIX_W-1:0] MONO_THRESHOLD = PIX_W'(128);
    localparam logic [PIX_W-1:0] PIX_WHITE      = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_BLACK      = PIX_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_COLOR_MODE    = 3'd4
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_COLOR = 2'd0,
        MODE_GRAY  = 2'd1,
        MODE_MONO  = 2'd2
    } color_mode_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             row_end;
        logic             frame_end;
    } pixel_out_t;

    // Sampling decision for one source pixel.
    typedef struct packed {
        logic take;
        logic row_end;
        logic frame_end;
    } sample_t;

endpackage

[rtl/ndl_size_eval.sv]
// Effective frame sizes: zero becomes one, large values saturate, target clamps to source.
// Depends on ndl_pkg.
`timescale 1ns / 1ps

module ndl_size_eval import ndl_pkg::*; #(
    parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF,
    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  logic [CFG_W-1:0] source_width,
    input  logic [CFG_W-1:0] source_height,
    input  logic [CFG_W-1:0] target_width,
    input  logic [CFG_W-1:0] target_height,
    output logic [DIM_W-1:0] eff_w,
    output logic [DIM_W-1:0] eff_h,
    output logic [DIM_W-1:0] eff_tw,
    output logic [DIM_W-1:0] eff_th
);

    localparam int unsigned CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;
    localparam logic [CMP_W-1:0] MaxDim = CMP_W'(MAX_DIMENSION);

    function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve == '0) begin
            return DIM_W'(1);
        end else if (ve > MaxDim) begin
            return DIM_W'(MAX_DIMENSION);
        end else begin
            return DIM_W'(ve);
        end
    endfunction

    logic [DIM_W-1:0] tw_c;
    logic [DIM_W-1:0] th_c;

    assign eff_w  = clamp_size(source_width);
    assign eff_h  = clamp_size(source_height);
    assign tw_c   = clamp_size(target_width);
    assign th_c   = clamp_size(target_height);
    assign eff_tw = (tw_c < eff_w) ? tw_c : eff_w;
    assign eff_th = (th_c < eff_h) ? th_c : eff_h;

endmodule

[rtl/ndl_sampler.sv]
// Row and column selection by Bresenham remainders, one source pixel per step.
// Depends on ndl_pkg.
`timescale 1ns / 1ps

module ndl_sampler import ndl_pkg::*; #(
    parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF,
    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1)
) (
    input  logic             aclk,
    input  logic             restart,
    input  logic             step,
    input  logic [DIM_W-1:0] w,
    input  logic [DIM_W-1:0] h,
    input  logic [DIM_W-1:0] tw,
    input  logic [DIM_W-1:0] th,
    input  logic [DIM_W-1:0] start_w,
    input  logic [DIM_W-1:0] start_h,
    input  logic [DIM_W-1:0] start_th,
    output sample_t          sample
);

    localparam int unsigned REM_W = DIM_W + 1;
    localparam int unsigned SUM_W = REM_W + 1;

    logic [DIM_W-1:0] scol_reg, scol_next;
    logic [DIM_W-1:0] srow_reg, srow_next;
    logic [DIM_W-1:0] ocol_reg, ocol_next;
    logic [DIM_W-1:0] orow_reg, orow_next;
    logic [REM_W-1:0] crem_reg, crem_next;
    logic [REM_W-1:0] rrem_reg, rrem_next;
    logic             rsel_reg, rsel_next;

    logic [REM_W-1:0] w2, h2, tw2, th2, th2_st;
    logic [SUM_W-1:0] crem_sum, rrem_sum;
    logic [REM_W-1:0] rrem_line;
    logic [DIM_W-1:0] scol_inc, srow_inc, orow_inc;
    logic             take;

    assign w2     = {w, 1'b0};
    assign h2     = {h, 1'b0};
    assign tw2    = {tw, 1'b0};
    assign th2    = {th, 1'b0};
    assign th2_st = {start_th, 1'b0};

    assign take = rsel_reg && (orow_reg < th) && (crem_reg < tw2) && (ocol_reg < tw);

    assign sample.take      = take;
    assign sample.row_end   = (ocol_reg == tw - DIM_W'(1));
    assign sample.frame_end = sample.row_end && (orow_reg == th - DIM_W'(1));

    assign crem_sum = take ? (SUM_W'(crem_reg) + SUM_W'(w2) - SUM_W'(tw2))
                           : (SUM_W'(crem_reg) - SUM_W'(tw2));
    assign rrem_sum = rsel_reg ? (SUM_W'(rrem_reg) + SUM_W'(h2) - SUM_W'(th2))
                               : (SUM_W'(rrem_reg) - SUM_W'(th2));
    assign rrem_line = rrem_sum[REM_W-1:0];

    assign scol_inc = scol_reg + DIM_W'(1);
    assign srow_inc = srow_reg + DIM_W'(1);
    assign orow_inc = orow_reg + DIM_W'(rsel_reg);

    always_comb begin
        scol_next = scol_reg;
        srow_next = srow_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        crem_next = crem_reg;
        rrem_next = rrem_reg;
        rsel_next = rsel_reg;
        if (restart) begin
            scol_next = '0;
            srow_next = '0;
            ocol_next = '0;
            orow_next = '0;
            crem_next = REM_W'(start_w);
            rrem_next = REM_W'(start_h);
            rsel_next = REM_W'(start_h) < th2_st;
        end else if (step) begin
            scol_next = scol_inc;
            ocol_next = ocol_reg + DIM_W'(take);
            crem_next = crem_sum[REM_W-1:0];
            if (scol_inc >= w) begin
                scol_next = '0;
                ocol_next = '0;
                crem_next = REM_W'(w);
                if (srow_inc >= h) begin
                    // Last pixel of the source frame: begin the next frame.
                    srow_next = '0;
                    orow_next = '0;
                    rrem_next = REM_W'(h);
                    rsel_next = REM_W'(h) < th2;
                end else begin
                    srow_next = srow_inc;
                    orow_next = orow_inc;
                    rrem_next = rrem_line;
                    rsel_next = (rrem_line < th2) && (orow_inc < th);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        scol_reg <= scol_next;
        srow_reg <= srow_next;
        ocol_reg <= ocol_next;
        orow_reg <= orow_next;
        crem_reg <= crem_next;
        rrem_reg <= rrem_next;
        rsel_reg <= rsel_next;
    end

endmodule

[rtl/ndl_luma.sv]
// Color conversion of one selected pixel: passthrough, luma, or thresholded luma.
// Depends on ndl_pkg.
`timescale 1ns / 1ps

module ndl_luma import ndl_pkg::*; (
    input  pixel_in_t        pix,
    input  sample_t          smp,
    input  logic [MODE_W-1:0] mode,
    output pixel_out_t       res
);

    logic [15:0]      luma_sum;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] mono;

    assign luma_sum = LUMA_R * 16'(pix.red_in) + LUMA_G * 16'(pix.green_in)
                    + LUMA_B * 16'(pix.blue_in);
    assign luma = luma_sum[15:8];
    assign mono = (luma >= MONO_THRESHOLD) ? PIX_WHITE : PIX_BLACK;

    always_comb begin
        res.row_end   = smp.row_end;
        res.frame_end = smp.frame_end;
        case (mode)
            MODE_GRAY: begin
                res.red_out   = luma;
                res.green_out = luma;
                res.blue_out  = luma;
            end
            MODE_MONO: begin
                res.red_out   = mono;
                res.green_out = mono;
                res.blue_out  = mono;
            end
            default: begin
                // Color mode and the unused code pass the pixel through.
                res.red_out   = pix.red_in;
                res.green_out = pix.green_in;
                res.blue_out  = pix.blue_in;
            end
        endcase
    end

endmodule

[rtl/nearest_downscale_luma_stream_core.sv]
// Nearest-neighbor downscaler with optional gray or monochrome output.
// A selected pixel passes stage one and then the output register before it is offered on m_valid.
// Throughput: one source pixel per cycle while the output is not stalled; the remainder update is one add and compare.
// Reset (aresetn low, synchronous) restores 640x480 to 640x480 in color mode and empties both
// pipeline registers. Depends on ndl_pkg, ndl_size_eval, ndl_sampler and ndl_luma.
`timescale 1ns / 1ps

module nearest_downscale_luma_stream_core import ndl_pkg::*; #(
    parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pixel_in_t            s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pixel_out_t           m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);

    // Configuration registers. Their next value already includes reset, so the
    // start-of-frame state can be derived from it in the same cycle.
    logic [CFG_W-1:0]  src_w_reg, src_w_next;
    logic [CFG_W-1:0]  src_h_reg, src_h_next;
    logic [CFG_W-1:0]  tgt_w_reg, tgt_w_next;
    logic [CFG_W-1:0]  tgt_h_reg, tgt_h_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              cfg_hit;
    logic              restart;

    // Sizes in force now, and sizes that will be in force after this edge.
    logic [DIM_W-1:0] w, h, tw, th;
    logic [DIM_W-1:0] nw, nh, ntw, nth;

    // Stage one holds the accepted pixel with its sampling decision; the
    // output register holds the finished result.
    logic       s1_valid_reg, s1_valid_next;
    pixel_in_t  s1_pix_reg;
    sample_t    s1_smp_reg;
    logic       m_valid_reg, m_valid_next;
    pixel_out_t m_data_reg;

    sample_t    smp;
    pixel_out_t res;
    logic       s_accept;
    logic       out_free;
    logic       s1_advance;

    // Configuration writes are always taken; an index beyond the register list
    // is ignored and does not restart the frame.
    assign cfg_ready = 1'b1;

    always_comb begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        tgt_w_next = tgt_w_reg;
        tgt_h_next = tgt_h_reg;
        mode_next  = mode_reg;
        cfg_hit    = 1'b0;
        if (!aresetn) begin
            src_w_next = SOURCE_WIDTH_RST;
            src_h_next = SOURCE_HEIGHT_RST;
            tgt_w_next = TARGET_WIDTH_RST;
            tgt_h_next = TARGET_HEIGHT_RST;
            mode_next  = MODE_COLOR;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SOURCE_WIDTH: begin
                    src_w_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_SOURCE_HEIGHT: begin
                    src_h_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_TARGET_WIDTH: begin
                    tgt_w_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_TARGET_HEIGHT: begin
                    tgt_h_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                CFG_COLOR_MODE: begin
                    mode_next = cfg_data[MODE_W-1:0];
                    cfg_hit   = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Any register write starts a fresh frame, as does reset.
    assign restart = !aresetn || cfg_hit;

    ndl_size_eval #(.MAX_DIMENSION(MAX_DIMENSION)) u_size_now (
        .source_width  (src_w_reg),
        .source_height (src_h_reg),
        .target_width  (tgt_w_reg),
        .target_height (tgt_h_reg),
        .eff_w         (w),
        .eff_h         (h),
        .eff_tw        (tw),
        .eff_th        (th)
    );

    ndl_size_eval #(.MAX_DIMENSION(MAX_DIMENSION)) u_size_next (
        .source_width  (src_w_next),
        .source_height (src_h_next),
        .target_width  (tgt_w_next),
        .target_height (tgt_h_next),
        .eff_w         (nw),
        .eff_h         (nh),
        .eff_tw        (ntw),
        .eff_th        (nth)
    );

    // Handshake: a dropped pixel leaves stage one freely; a selected one needs
    // room in the output register. The input side stays open as long as stage
    // one can move on, so a pixel is taken every cycle without backpressure.
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && (!s1_smp_reg.take || out_free);
    assign s_ready    = aresetn && (!s1_valid_reg || s1_advance);
    assign s_accept   = s_valid && s_ready;

    ndl_sampler #(.MAX_DIMENSION(MAX_DIMENSION)) u_sampler (
        .aclk     (aclk),
        .restart  (restart),
        .step     (s_accept),
        .w        (w),
        .h        (h),
        .tw       (tw),
        .th       (th),
        .start_w  (nw),
        .start_h  (nh),
        .start_th (nth),
        .sample   (smp)
    );

    ndl_luma u_luma (
        .pix  (s1_pix_reg),
        .smp  (s1_smp_reg),
        .mode (mode_reg),
        .res  (res)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_advance && s1_smp_reg.take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        src_w_reg <= src_w_next;
        src_h_reg <= src_h_next;
        tgt_w_reg <= tgt_w_next;
        tgt_h_reg <= tgt_h_next;
        mode_reg  <= mode_next;
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        if (s_accept) begin
            s1_pix_reg <= s_data;
            s1_smp_reg <= smp;
        end
        if (s1_advance && s1_smp_reg.take) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/ndl_checker.sv]
// Port-level checks for the downscaler, attached to every instance by bind.
// Depends on ndl_pkg and nearest_downscale_luma_stream_core.
`timescale 1ns / 1ps

module ndl_checker import ndl_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input pixel_out_t m_data
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // The end of a frame is always the end of an output row.
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_end |-> m_data.row_end)
        else $error("frame end without row end");

    // Reset empties the pipeline and blocks input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_reset_block: assert property (@(posedge aclk)
        !aresetn |-> !(s_valid && s_ready))
        else $error("request accepted during reset");

endmodule

bind nearest_downscale_luma_stream_core ndl_checker u_ndl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
